@@ rtl/mkvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkvs_pkg: shared types and codes for the mailbox key/value store
// Request and message codes, the key table entry layout and result helpers.
// ----------------------------------------------------------------------------
package mkvs_pkg;

  localparam logic [1:0] CMD_MESSAGE = 2'd0;
  localparam logic [1:0] CMD_STAGE   = 2'd1;
  localparam logic [1:0] CMD_DEFINE  = 2'd2;

  localparam logic [7:0] SERVED_EP  = 8'h20;

  localparam logic [7:0] T_READ     = 8'h10;
  localparam logic [7:0] T_WRITE    = 8'h11;
  localparam logic [7:0] T_BY_INDEX = 8'h12;
  localparam logic [7:0] T_INFO     = 8'h13;
  localparam logic [7:0] T_INIT     = 8'h17;

  localparam logic [7:0] R_NOT_FOUND     = 8'h84;
  localparam logic [7:0] R_NOT_WRITABLE  = 8'h86;
  localparam logic [7:0] R_SIZE_MISMATCH = 8'h87;

  localparam logic [7:0] FLAG_VALID    = 8'h80;
  localparam logic [7:0] FLAG_WRITABLE = 8'h40;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd1;
  localparam logic [1:0] ST_NOT_WRITABLE = 2'd2;
  localparam logic [1:0] ST_SIZE_MISMATCH = 2'd3;

  localparam logic [15:0] INFO_SIZE = 16'd6;

  typedef struct packed {
    logic [31:0] name;
    logic [31:0] ktype;
    logic [6:0]  size;
    logic        writable;
  } key_ent_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] reply_message;
    logic [2:0]  buffer_offset;
    logic [63:0] buffer_word;
    logic [1:0]  status;
    logic        last;
  } res_t;

  function automatic res_t reply_res(input logic [63:0] msg, input logic [1:0] st);
    res_t r;
    r.kind          = 1'b0;
    r.reply_message = msg;
    r.buffer_offset = 3'd0;
    r.buffer_word   = 64'd0;
    r.status        = st;
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic res_t word_res(input logic [2:0] off, input logic [63:0] word);
    res_t r;
    r.kind          = 1'b1;
    r.reply_message = 64'd0;
    r.buffer_offset = off;
    r.buffer_word   = word;
    r.status        = ST_OK;
    r.last          = 1'b0;
    return r;
  endfunction

  // keep the first rem bytes, all eight when rem is eight or more
  function automatic logic [63:0] byte_mask(input logic [7:0] rem);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (rem > 8'(b)) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ rtl/mailbox_key_value_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mailbox_key_value_store_unit: mailbox-driven key/value store
// Key table and value words live in two synchronous RAMs; a sequencer
// searches, reads and writes them and emits buffer words and one reply per served message.
// ----------------------------------------------------------------------------
// channel   | handshake               | payload
// request   | start, busy             | command, endpoint, message, key_*, word_index, data_word
// result    | strobe (no stall)       | kind, reply_message, buffer_offset, buffer_word, status, last
// config    | cfg_we                  | cfg_data (shared buffer address)
//
// Stage writes the staging buffer without leaving idle. Define: one value word per cycle.
// Messages: key search reads and compares each table entry visited; a large read
// issues and emits each value word, a write stores every value word; reply follows.
// Synchronous reset clears the entry count, staging buffer and sequencer;
// the RAMs are not cleared. Results leave through a register.
// ----------------------------------------------------------------------------
module mailbox_key_value_store_unit #(
  parameter int MAX_ENTRIES = 128,
  parameter int VALUE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  endpoint,
  input  logic [63:0] message,
  input  logic [31:0] key_name,
  input  logic [31:0] key_type,
  input  logic [6:0]  key_size,
  input  logic        key_writable,
  input  logic [2:0]  word_index,
  input  logic [63:0] data_word,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  output logic        strobe,
  output logic        kind,
  output logic [63:0] reply_message,
  output logic [2:0]  buffer_offset,
  output logic [63:0] buffer_word,
  output logic [1:0]  status,
  output logic        last
);

  localparam int ENTRY_WORDS = (VALUE_BYTES + 7) / 8;
  localparam int WB  = (ENTRY_WORDS > 1) ? $clog2(ENTRY_WORDS) : 1;
  localparam int IXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = IXW + WB;
  localparam int DDEPTH = MAX_ENTRIES * (1 << WB);
  localparam logic [2:0] LAST_WORD = 3'(ENTRY_WORDS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEF, S_SRCH_RD, S_SRCH_CMP, S_IDX_RD, S_IDX_CMP,
    S_RD_ISSUE, S_RD_EMIT, S_WR_DATA, S_REPLY
  } state_t;

  state_t state;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  srch;
  logic [IXW-1:0] hit;
  logic [2:0]     w;
  logic [63:0]    msg;
  logic [6:0]     dsize;
  logic [6:0]     ksz;
  logic [63:0]    sba;
  logic [63:0]    staging [8];
  logic [63:0]    rep;
  logic [1:0]     rep_st;
  mkvs_pkg::res_t res;
  logic           strobe_r;

  mkvs_pkg::key_ent_t key_mem [MAX_ENTRIES];
  logic [63:0]        data_mem [DDEPTH];
  mkvs_pkg::key_ent_t key_rd;
  logic [63:0]        data_rd;

  logic               accept;
  logic               key_we;
  mkvs_pkg::key_ent_t key_wdata;
  logic [IXW-1:0]     key_raddr;
  logic               data_we;
  logic [AW-1:0]      data_waddr;
  logic [AW-1:0]      data_raddr;
  logic [63:0]        data_wdata;
  logic [7:0]         wsize;
  logic [7:0]         rem;
  logic [31:0]        mkey;
  logic [7:0]         mtype;
  logic [63:0]        id_reply;
  logic [6:0]         rsize;
  logic [2:0]         rwords_last;
  logic               def_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign mkey   = msg[63:32];
  assign mtype  = msg[7:0];
  assign id_reply = {48'd0, msg[15:12], 12'd0};

  assign def_ok = (cnt < CW'(MAX_ENTRIES)) && (key_size <= 7'(VALUE_BYTES));
  assign key_we = accept && (command == mkvs_pkg::CMD_DEFINE) && def_ok;
  assign key_wdata = '{name: key_name, ktype: key_type, size: key_size,
                       writable: key_writable};
  assign key_raddr = (state == S_IDX_RD) ? mkey[IXW-1:0] : srch[IXW-1:0];

  assign wsize = (state == S_DEF) ? {1'b0, dsize} : msg[23:16];
  assign rem   = (wsize > {2'b00, w, 3'b000}) ? (wsize - {2'b00, w, 3'b000}) : 8'd0;
  assign data_we    = (state == S_DEF) || (state == S_WR_DATA);
  assign data_waddr = (state == S_DEF) ? {cnt[IXW-1:0], w[WB-1:0]} : {hit, w[WB-1:0]};
  assign data_wdata = staging[w] & mkvs_pkg::byte_mask(rem);
  assign data_raddr = {hit, w[WB-1:0]};

  assign rsize = key_rd.size;
  assign rwords_last = 3'((ksz + 7'd7) >> 3) - 3'd1;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[cnt[IXW-1:0]] <= key_wdata;
    end
    key_rd <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rd <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sba <= 64'd0;
    end else if (cfg_we) begin
      sba <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      strobe_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        staging[i] <= 64'd0;
      end
    end else begin
      strobe_r <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            msg   <= message;
            dsize <= key_size;
            w     <= 3'd0;
            srch  <= '0;
            priority if (command == mkvs_pkg::CMD_STAGE) begin
              staging[word_index] <= data_word;
            end else if (command == mkvs_pkg::CMD_DEFINE) begin
              if (def_ok) state <= S_DEF;
            end else if (command == mkvs_pkg::CMD_MESSAGE &&
                         endpoint == mkvs_pkg::SERVED_EP) begin
              priority if (message[7:0] == mkvs_pkg::T_INIT) begin
                res <= mkvs_pkg::reply_res(sba, mkvs_pkg::ST_OK);
                strobe_r <= 1'b1;
              end else if (message[7:0] == mkvs_pkg::T_BY_INDEX) begin
                if (message[63:32] >= 32'(cnt)) begin
                  res <= mkvs_pkg::reply_res({48'd0, message[15:12], 4'd0,
                                             mkvs_pkg::R_NOT_FOUND},
                                             mkvs_pkg::ST_NOT_FOUND);
                  strobe_r <= 1'b1;
                end else begin
                  state <= S_IDX_RD;
                end
              end else if ((message[7:0] == mkvs_pkg::T_READ ||
                            message[7:0] == mkvs_pkg::T_WRITE ||
                            message[7:0] == mkvs_pkg::T_INFO) && cnt != '0) begin
                state <= S_SRCH_RD;
              end else begin
                res <= mkvs_pkg::reply_res({48'd0, message[15:12], 4'd0,
                                           mkvs_pkg::R_NOT_FOUND},
                                           mkvs_pkg::ST_NOT_FOUND);
                strobe_r <= 1'b1;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DEF: begin
          if (w == LAST_WORD) begin
            cnt   <= cnt + 1'b1;
            state <= S_IDLE;
          end else begin
            w <= w + 3'd1;
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (key_rd.name == mkey) begin
            hit <= srch[IXW-1:0];
            ksz <= rsize;
            priority if (mtype == mkvs_pkg::T_READ) begin
              if (msg[23:16] < {1'b0, rsize}) begin
                res <= mkvs_pkg::reply_res(id_reply | 64'(mkvs_pkg::R_SIZE_MISMATCH),
                                           mkvs_pkg::ST_SIZE_MISMATCH);
                strobe_r <= 1'b1;
                state <= S_IDLE;
              end else begin
                rep    <= id_reply | {32'd0, 9'd0, rsize, 16'd0};
                rep_st <= mkvs_pkg::ST_OK;
                state  <= S_RD_ISSUE;
              end
            end else if (mtype == mkvs_pkg::T_WRITE) begin
              priority if (!key_rd.writable) begin
                res <= mkvs_pkg::reply_res(id_reply | 64'(mkvs_pkg::R_NOT_WRITABLE),
                                           mkvs_pkg::ST_NOT_WRITABLE);
                strobe_r <= 1'b1;
                state <= S_IDLE;
              end else if (msg[23:16] != {1'b0, rsize}) begin
                res <= mkvs_pkg::reply_res(id_reply | 64'(mkvs_pkg::R_SIZE_MISMATCH),
                                           mkvs_pkg::ST_SIZE_MISMATCH);
                strobe_r <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_WR_DATA;
              end
            end else begin
              res <= mkvs_pkg::word_res(3'd0, {16'd0,
                       mkvs_pkg::FLAG_VALID |
                       (key_rd.writable ? mkvs_pkg::FLAG_WRITABLE : 8'h00),
                       key_rd.ktype[7:0], key_rd.ktype[15:8],
                       key_rd.ktype[23:16], key_rd.ktype[31:24], 1'b0, rsize});
              strobe_r <= 1'b1;
              rep    <= id_reply | {32'd0, mkvs_pkg::INFO_SIZE, 16'd0};
              rep_st <= mkvs_pkg::ST_OK;
              state  <= S_REPLY;
            end
          end else if (srch + 1'b1 == cnt) begin
            res <= mkvs_pkg::reply_res(id_reply | 64'(mkvs_pkg::R_NOT_FOUND),
                                       mkvs_pkg::ST_NOT_FOUND);
            strobe_r <= 1'b1;
            state <= S_IDLE;
          end else begin
            srch  <= srch + 1'b1;
            state <= S_SRCH_RD;
          end
        end
        S_IDX_RD: begin
          state <= S_IDX_CMP;
        end
        S_IDX_CMP: begin
          res <= mkvs_pkg::reply_res(id_reply | {key_rd.name[7:0], key_rd.name[15:8],
                                     key_rd.name[23:16], key_rd.name[31:24], 32'd0},
                                     mkvs_pkg::ST_OK);
          strobe_r <= 1'b1;
          state <= S_IDLE;
        end
        S_RD_ISSUE: begin
          state <= S_RD_EMIT;
        end
        S_RD_EMIT: begin
          if (ksz <= 7'd4) begin
            res <= mkvs_pkg::reply_res(rep | {data_rd[31:0], 32'd0}, rep_st);
            strobe_r <= 1'b1;
            state <= S_IDLE;
          end else begin
            res <= mkvs_pkg::word_res(w, data_rd);
            strobe_r <= 1'b1;
            if (w == rwords_last) begin
              state <= S_REPLY;
            end else begin
              w     <= w + 3'd1;
              state <= S_RD_ISSUE;
            end
          end
        end
        S_WR_DATA: begin
          if (w == LAST_WORD) begin
            rep    <= id_reply;
            rep_st <= mkvs_pkg::ST_OK;
            state  <= S_REPLY;
          end else begin
            w <= w + 3'd1;
          end
        end
        S_REPLY: begin
          res <= mkvs_pkg::reply_res(rep, rep_st);
          strobe_r <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign strobe        = strobe_r;
  assign kind          = res.kind;
  assign reply_message = res.reply_message;
  assign buffer_offset = res.buffer_offset;
  assign buffer_word   = res.buffer_word;
  assign status        = res.status;
  assign last          = res.last;

endmodule

@@ rtl/mkvs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkvs_checker: port-level checks for the mailbox key/value store
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mkvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  command,
  input logic [7:0]  endpoint,
  input logic        strobe,
  input logic        kind,
  input logic [63:0] reply_message,
  input logic [1:0]  status,
  input logic        last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("busy or strobe after reset");

  a_word_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind |-> !last && status == mkvs_pkg::ST_OK && reply_message == 64'd0)
    else $error("buffer word marked last or carries reply fields");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !kind |-> last)
    else $error("reply not marked last");

  a_stage_no_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == mkvs_pkg::CMD_STAGE |=> !strobe && !busy)
    else $error("stage request produced a result");

  a_foreign_ep: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == mkvs_pkg::CMD_MESSAGE &&
    endpoint != mkvs_pkg::SERVED_EP |=> !strobe && !busy)
    else $error("message on foreign endpoint served");

endmodule

bind mailbox_key_value_store_unit mkvs_checker u_mkvs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
  .endpoint(endpoint), .strobe(strobe), .kind(kind),
  .reply_message(reply_message), .status(status), .last(last)
);
